[hdl/wits_pkg.sv]
// Shared types, constants and elaboration-time tables for the Weibull sampler.
// Used by wits_lg, wits_exp and weibull_inverse_transform_sampler_top.
package wits_pkg;

  localparam int UNIFORM_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SHAPE = 2'd1;

  localparam logic [31:0] SCALE_RST     = 32'd65536;
  localparam logic [23:0] INV_SHAPE_RST = 24'd65536;

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [63:0] LN2_Q64 = 64'hB172_17F7_D1CF_79AB;

  typedef logic [31:0][63:0] root_tab_t;

  typedef struct packed {
    logic       sat;
    logic       zero;
    logic [5:0] shift;
  } exp_tag_t;

  // truncated Q2.62 product assembled from four 32x32 partial products
  function automatic logic [63:0] q62_sum(logic [63:0] ll, logic [63:0] lh,
                                          logic [63:0] hl, logic [63:0] hh);
    logic [127:0] full;
    full = {hh, 64'd0} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {64'd0, ll};
    return full[125:62];
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] t);
    logic [63:0]  s;
    logic [63:0]  c;
    logic [127:0] sq;
    s = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = s | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= t) s = c;
    end
    return s;
  endfunction

  function automatic root_tab_t make_roots();
    root_tab_t    tab;
    logic [63:0]  v;
    v = 64'h8000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      v      = isqrt128({64'd0, v} << 62);
      tab[i] = v;
    end
    return tab;
  endfunction

  // log2 with 32 fraction bits of a constant whose top bit is set
  function automatic logic [63:0] log2_top_const(logic [63:0] x);
    logic [63:0]  mant;
    logic [31:0]  frac;
    logic [127:0] p;
    mant = x >> 1;
    frac = '0;
    for (int i = 31; i >= 0; i--) begin
      p    = {64'd0, mant} * {64'd0, mant};
      mant = p[125:62];
      if (mant[63]) begin
        mant    = mant >> 1;
        frac[i] = 1'b1;
      end
    end
    return {25'd0, 7'd63, frac};
  endfunction

  localparam root_tab_t   ROOT_TAB = make_roots();
  localparam logic [63:0] LN2_LOG  = log2_top_const(LN2_Q64);
  localparam logic signed [63:0] LY_OFS = $signed(LN2_LOG) - (64'sd112 <<< 32);

endpackage

[hdl/weibull_inverse_transform_sampler_top.sv]
// Throughput: one transaction per cycle; every stage, the three log2 pipelines
// and the 2^f pipeline advance together on one enable that drops only while a
// result is held on the output. Reset (rst_n low, synchronous) clears all valid
// bits and loads scale = 1.0 and inv_shape = 1.0. Depends on wits_pkg, wits_lg, wits_exp.
module weibull_inverse_transform_sampler_top #(
  parameter int UNIFORM_BITS = wits_pkg::UNIFORM_BITS_DEF,
  parameter int FRAC_BITS    = wits_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [wits_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [UNIFORM_BITS-1:0]        in_uniform,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_sample,
  output logic                           out_saturated
);

  localparam int LY_W = 40;
  localparam int LS_W = 38;
  localparam int T_W  = 65 - FRAC_BITS;
  localparam int N_W  = T_W - 32;
  localparam logic signed [T_W-1:0] T_SAT = T_W'(64'sd32 <<< 32);

  logic [31:0] scale_r;
  logic [23:0] inv_shape_r;
  logic        en;

  logic [63:0] m0_r;
  logic        z0_r, v0_r;
  logic [63:0] lgm;
  logic        vm, zm;
  logic [63:0] d1_r;
  logic        z1_r, v1_r;
  logic [63:0] lgd, lgs;
  logic        vd, vs, zd, zs;

  logic signed [LY_W-1:0] ly2_r;
  logic [LS_W-1:0]        lgs2_r, lgs3_r;
  logic                   z2_r, v2_r, z3_r, v3_r, z4_r, v4_r;
  logic [43:0]            pl3_r;
  logic signed [44:0]     ph3_r;
  logic signed [T_W-1:0]  t4_r;

  logic signed [63:0]    prod_w, tfull_w;
  logic signed [N_W-1:0] n_w;
  logic                  sat_w, low_w;
  logic [6:0]            sh_w;

  logic                   v5_r;
  logic [31:0]            f5_r;
  wits_pkg::exp_tag_t     tag5_r;
  logic [63:0]            mant;
  logic                   ve;
  wits_pkg::exp_tag_t     tage;

  logic        out_valid_r;
  logic [31:0] sample_r, sample_nxt;
  logic        saturated_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= wits_pkg::SCALE_RST;
      inv_shape_r <= wits_pkg::INV_SHAPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wits_pkg::CFG_SCALE:     scale_r     <= cfg_data;
        wits_pkg::CFG_INV_SHAPE: inv_shape_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= vm;
      v2_r <= vd;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      out_valid_r <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r <= (64'd1 << UNIFORM_BITS) - 64'(in_uniform);
      z0_r <= (in_uniform == '0);
    end
  end

  wits_lg #(.NFRAC(48)) u_lg_m (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v0_r), .in_x(m0_r), .in_tag(z0_r),
    .out_valid(vm), .out_lg(lgm), .out_tag(zm)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r <= (64'(UNIFORM_BITS) << 48) - lgm;
      z1_r <= zm;
    end
  end

  wits_lg #(.NFRAC(32)) u_lg_d (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .in_x(d1_r), .in_tag(z1_r),
    .out_valid(vd), .out_lg(lgd), .out_tag(zd)
  );

  wits_lg #(.NFRAC(32)) u_lg_s (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v1_r), .in_x(64'(scale_r)), .in_tag(scale_r == '0),
    .out_valid(vs), .out_lg(lgs), .out_tag(zs)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ly2_r  <= LY_W'($signed(lgd) + wits_pkg::LY_OFS);
      lgs2_r <= lgs[LS_W-1:0];
      z2_r   <= zd || zs;
      pl3_r  <= 44'(inv_shape_r) * 44'(ly2_r[19:0]);
      ph3_r  <= $signed({1'b0, inv_shape_r}) * $signed(ly2_r[LY_W-1:20]);
      lgs3_r <= lgs2_r;
      z3_r   <= z2_r;
      t4_r   <= T_W'(tfull_w);
      z4_r   <= z3_r;
    end
  end

  assign prod_w  = (64'(ph3_r) <<< 20) + $signed(64'(pl3_r));
  assign tfull_w = (prod_w >>> FRAC_BITS) + $signed(64'(lgs3_r));

  assign sat_w = (t4_r >= T_SAT);
  assign n_w   = t4_r[T_W-1:32];
  assign low_w = (n_w < -1);
  assign sh_w  = 7'd62 - 7'(n_w);

  always_ff @(posedge clk) begin
    if (en) begin
      f5_r         <= t4_r[31:0];
      tag5_r.sat   <= !z4_r && sat_w;
      tag5_r.zero  <= z4_r || low_w;
      tag5_r.shift <= sh_w[5:0];
    end
  end

  wits_exp u_exp (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v5_r), .in_frac(f5_r), .in_tag(tag5_r),
    .out_valid(ve), .out_mant(mant), .out_tag(tage)
  );

  always_comb begin
    if (tage.sat) begin
      sample_nxt = '1;
    end else if (tage.zero) begin
      sample_nxt = '0;
    end else begin
      sample_nxt = 32'(mant >> tage.shift);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r    <= sample_nxt;
      saturated_r <= tage.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = sample_r;
  assign out_saturated = saturated_r;

`ifndef SYNTHESIS
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n) vd == vs)
    else $error("log2 lanes out of step");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_valid_r) && $stable(sample_r))
    else $error("output moved while held");
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && saturated_r |-> sample_r == '1)
    else $error("saturated transaction without full-scale sample");
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");
`endif

endmodule

[hdl/wits_lg.sv]
// Pipelined fixed-point base-2 logarithm, one fraction bit per two stages.
// Depends on wits_pkg for the Q2.62 product assembly.
module wits_lg #(
  parameter int NFRAC = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_x,
  input  logic        in_tag,
  output logic        out_valid,
  output logic [63:0] out_lg,
  output logic        out_tag
);

  function automatic logic [6:0] lead_one(logic [63:0] x);
    logic [6:0] e;
    e = '0;
    for (int i = 0; i < 64; i++)
      if (x[i]) e = 7'(i);
    return e;
  endfunction

  logic [63:0] x1_r;
  logic [6:0]  e1_r;
  logic        v1_r;
  logic        t1_r;

  logic [63:0]      mb_r [NFRAC+1];
  logic [6:0]       eb_r [NFRAC+1];
  logic [NFRAC-1:0] fb_r [NFRAC+1];
  logic             vb_r [NFRAC+1];
  logic             tb_r [NFRAC+1];

  logic [63:0]      ll_r [NFRAC];
  logic [63:0]      lh_r [NFRAC];
  logic [63:0]      hl_r [NFRAC];
  logic [63:0]      hh_r [NFRAC];
  logic [6:0]       ea_r [NFRAC];
  logic [NFRAC-1:0] fa_r [NFRAC];
  logic             va_r [NFRAC];
  logic             ta_r [NFRAC];
  logic [63:0]      sq_w [NFRAC];

  logic [63:0] mant_nxt;
  logic [6:0]  lsh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_x;
      e1_r <= lead_one(in_x);
      t1_r <= in_tag;
    end
  end

  assign lsh      = 7'd62 - e1_r;
  assign mant_nxt = (e1_r <= 7'd62) ? (x1_r << lsh[5:0]) : (x1_r >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r[0] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mb_r[0] <= mant_nxt;
      eb_r[0] <= e1_r;
      fb_r[0] <= '0;
      tb_r[0] <= t1_r;
    end
  end

  for (genvar k = 0; k < NFRAC; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[k]   <= 1'b0;
        vb_r[k+1] <= 1'b0;
      end else if (en) begin
        va_r[k]   <= vb_r[k];
        vb_r[k+1] <= va_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ll_r[k] <= mb_r[k][31:0]  * mb_r[k][31:0];
        lh_r[k] <= mb_r[k][31:0]  * mb_r[k][63:32];
        hl_r[k] <= mb_r[k][63:32] * mb_r[k][31:0];
        hh_r[k] <= mb_r[k][63:32] * mb_r[k][63:32];
        ea_r[k] <= eb_r[k];
        fa_r[k] <= fb_r[k];
        ta_r[k] <= tb_r[k];
      end
    end

    assign sq_w[k] = wits_pkg::q62_sum(ll_r[k], lh_r[k], hl_r[k], hh_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        mb_r[k+1] <= sq_w[k][63] ? (sq_w[k] >> 1) : sq_w[k];
        eb_r[k+1] <= ea_r[k];
        fb_r[k+1] <= fa_r[k] | (NFRAC'(sq_w[k][63]) << (NFRAC - 1 - k));
        tb_r[k+1] <= ta_r[k];
      end
    end
  end

  assign out_valid = vb_r[NFRAC];
  assign out_lg    = 64'({eb_r[NFRAC], fb_r[NFRAC]});
  assign out_tag   = tb_r[NFRAC];

endmodule

[hdl/wits_exp.sv]
// Pipelined fixed-point 2^f for a 32-bit fraction, one root factor per two stages.
// Depends on wits_pkg for the root table, tag type and Q2.62 product assembly.
module wits_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        in_frac,
  input  wits_pkg::exp_tag_t in_tag,
  output logic               out_valid,
  output logic [63:0]        out_mant,
  output wits_pkg::exp_tag_t out_tag
);

  localparam int N = 32;

  logic [63:0]        mi_w [N];
  logic [31:0]        fi_w [N];
  logic               vi_w [N];
  wits_pkg::exp_tag_t ti_w [N];

  logic [63:0]        ll_r [N];
  logic [63:0]        lh_r [N];
  logic [63:0]        hl_r [N];
  logic [63:0]        hh_r [N];
  logic [63:0]        ma_r [N];
  logic [31:0]        fa_r [N];
  logic               ka_r [N];
  logic               va_r [N];
  wits_pkg::exp_tag_t ta_r [N];

  logic [63:0]        mb_r [N];
  logic [31:0]        fb_r [N];
  logic               vb_r [N];
  wits_pkg::exp_tag_t tb_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [63:0] ROOT = wits_pkg::ROOT_TAB[k];

    if (k == 0) begin : g_first
      assign mi_w[k] = wits_pkg::ONE_Q62;
      assign fi_w[k] = in_frac;
      assign vi_w[k] = in_valid;
      assign ti_w[k] = in_tag;
    end else begin : g_next
      assign mi_w[k] = mb_r[k-1];
      assign fi_w[k] = fb_r[k-1];
      assign vi_w[k] = vb_r[k-1];
      assign ti_w[k] = tb_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[k] <= 1'b0;
        vb_r[k] <= 1'b0;
      end else if (en) begin
        va_r[k] <= vi_w[k];
        vb_r[k] <= va_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ll_r[k] <= mi_w[k][31:0]  * ROOT[31:0];
        lh_r[k] <= mi_w[k][31:0]  * ROOT[63:32];
        hl_r[k] <= mi_w[k][63:32] * ROOT[31:0];
        hh_r[k] <= mi_w[k][63:32] * ROOT[63:32];
        ma_r[k] <= mi_w[k];
        fa_r[k] <= fi_w[k];
        ka_r[k] <= fi_w[k][N-1-k];
        ta_r[k] <= ti_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mb_r[k] <= ka_r[k] ? wits_pkg::q62_sum(ll_r[k], lh_r[k], hl_r[k], hh_r[k])
                           : ma_r[k];
        fb_r[k] <= fa_r[k];
        tb_r[k] <= ta_r[k];
      end
    end
  end

  assign out_valid = vb_r[N-1];
  assign out_mant  = mb_r[N-1];
  assign out_tag   = tb_r[N-1];

endmodule

[tb/weibull_inverse_transform_sampler_top_tb.sv]
// Self-checking testbench for weibull_inverse_transform_sampler_top.
// A scoreboard class predicts each sample in fixed point from its own copy of
// the registers; depends on wits_pkg for the register indexes and ln 2 constant.
module weibull_inverse_transform_sampler_top_tb;
  import wits_pkg::*;

  class weibull_scoreboard;
    logic [31:0] scale_q;
    logic [23:0] inv_shape_q;
    logic [63:0] roots[32];
    logic [63:0] ln2_log;
    logic [31:0] sample_q[$];
    logic        sat_q[$];
    int          errors;

    function new();
      logic [63:0]  v;
      logic [63:0]  s;
      logic [63:0]  c;
      logic [127:0] rad;
      scale_q     = SCALE_RST;
      inv_shape_q = INV_SHAPE_RST;
      errors      = 0;
      v = 64'h8000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
        rad = {64'd0, v} << 62;
        s = '0;
        for (int b = 63; b >= 0; b--) begin
          c = s | (64'd1 << b);
          if ({64'd0, c} * {64'd0, c} <= rad) s = c;
        end
        v = s;
        roots[i] = s;
      end
      ln2_log = log2_q(LN2_Q64, 32);
    endfunction

    function logic [63:0] mulq(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    function logic [63:0] log2_q(logic [63:0] x, int nfrac);
      int          e;
      logic [63:0] mant;
      logic [63:0] frac;
      e = 63;
      while (e > 0 && !x[e]) e--;
      mant = (e <= 62) ? (x << (62 - e)) : (x >> 1);
      frac = '0;
      for (int i = nfrac - 1; i >= 0; i--) begin
        mant = mulq(mant, mant);
        if (mant[63]) begin
          mant = mant >> 1;
          frac[i] = 1'b1;
        end
      end
      return (64'(e) << nfrac) | frac;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_SCALE) scale_q = data;
      else if (idx == CFG_INV_SHAPE) inv_shape_q = data[23:0];
    endfunction

    function void note_uniform(logic [23:0] u);
      logic [63:0]        m;
      logic [63:0]        d;
      logic [63:0]        mant;
      logic [31:0]        f;
      logic signed [63:0] ly;
      logic signed [63:0] t;
      logic signed [63:0] n;
      if (u == 0 || scale_q == 0) begin
        sample_q.push_back(32'd0);
        sat_q.push_back(1'b0);
        return;
      end
      m  = (64'd1 << 24) - 64'(u);
      d  = (64'd24 << 48) - log2_q(m, 48);
      ly = $signed(log2_q(d, 32)) + $signed(ln2_log) - (64'sd112 <<< 32);
      t  = (($signed({40'd0, inv_shape_q}) * ly) >>> 16) + $signed(log2_q(64'(scale_q), 32));
      if (t >= (64'sd32 <<< 32)) begin
        sample_q.push_back(32'hFFFF_FFFF);
        sat_q.push_back(1'b1);
        return;
      end
      n = t >>> 32;
      if (n < -1) begin
        sample_q.push_back(32'd0);
        sat_q.push_back(1'b0);
        return;
      end
      f = t[31:0];
      mant = ONE_Q62;
      for (int i = 0; i < 32; i++)
        if (f[31 - i]) mant = mulq(mant, roots[i]);
      mant = mant >> (62 - n);
      sample_q.push_back(mant[31:0]);
      sat_q.push_back(1'b0);
    endfunction

    function void check_sample(logic [31:0] s, logic sat);
      logic [31:0] es;
      logic        esat;
      if (sample_q.size() == 0) begin
        $error("unexpected result sample=%h saturated=%b", s, sat);
        errors++;
        return;
      end
      es   = sample_q.pop_front();
      esat = sat_q.pop_front();
      if (s !== es) begin
        $error("sample expected %h actual %h", es, s);
        errors++;
      end
      if (sat !== esat) begin
        $error("saturated expected %b actual %b", esat, sat);
        errors++;
      end
    endfunction

    function int pending();
      return sample_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [23:0]          in_uniform;
  logic                 out_valid;
  logic                 out_stall;
  logic [31:0]          out_sample;
  logic                 out_saturated;

  weibull_scoreboard sb;
  bit                long_hold;

  weibull_inverse_transform_sampler_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
    .in_uniform(in_uniform), .out_valid(out_valid), .out_stall(out_stall),
    .out_sample(out_sample), .out_saturated(out_saturated)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_sample(out_sample, out_saturated);
  end

  initial begin
    int k;
    out_stall <= 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        long_hold = 0;
      end
      k = $urandom_range(0, 3);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic send_uniform(logic [23:0] u, bit gaps);
    int k;
    k = gaps ? $urandom_range(0, 3) : 0;
    if (k > 0) begin
      in_valid <= 1'b0;
      repeat (k) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_uniform <= u;
    do @(posedge clk); while (in_stall);
    sb.note_uniform(u);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_uniform();
    case ($urandom_range(0, 9))
      0: return 24'(0);
      1: return 24'($urandom_range(1, 255));
      2: return 24'hFFFFFF - 24'($urandom_range(0, 255));
      3: return 24'($urandom) & (24'hFFFFFF >> $urandom_range(0, 23));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count, bit gaps);
    for (int i = 0; i < count; i++) send_uniform(rand_uniform(), gaps);
    drain();
  endtask

  initial begin
    logic [23:0] dir_u[8];
    sb = new();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_uniform <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_u = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h800000,
              24'h555555, 24'hAAAAAA, 24'h000100, 24'hFFFFFE};
    foreach (dir_u[i]) send_uniform(dir_u[i], 0);
    drain();
    write_reg(CFG_SCALE, 32'd1);
    write_reg(CFG_INV_SHAPE, 32'hFF00_0001);
    foreach (dir_u[i]) send_uniform(dir_u[i], 1);
    drain();
    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_INV_SHAPE, 32'h00FF_FFFF);
    write_reg(2'd2, 32'd0);
    write_reg(2'd3, $urandom);
    foreach (dir_u[i]) send_uniform(dir_u[i], 1);
    drain();

    write_reg(CFG_SCALE, 32'hFFFF_FFFF);
    write_reg(CFG_INV_SHAPE, 32'd1);
    random_phase(100, 1);
    write_reg(CFG_SCALE, 32'd1);
    write_reg(CFG_INV_SHAPE, 32'h00FF_FFFF);
    random_phase(100, 1);
    write_reg(CFG_SCALE, SCALE_RST);
    write_reg(CFG_INV_SHAPE, {8'hA5, INV_SHAPE_RST});
    long_hold = 1;
    random_phase(300, 0);
    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_SCALE, ($urandom_range(0, 1) ? $urandom : $urandom_range(1, 32'h40000)) | 32'd1);
      write_reg(CFG_INV_SHAPE, $urandom_range(1, p < 3 ? 32'h40000 : 32'hFFFFFF));
      random_phase(100, p != 2);
    end

    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
